// ===== design/double_ended_queue_top_macros.svh =====
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and held off
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH

// Check a property at every rising edge outside reset.
`define DEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define DEQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue package
// Sizes, opcode and status codes, controller states, item and command types,
// and the ring index helpers.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Ring size and derived widths
  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_COUNT      = 3'd6,
    OP_CLEAR      = 3'd7
  } deq_op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } deq_status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_DONE = 2'd2
  } deq_state_e;

  typedef struct packed {
    deq_op_e                  opcode;
    logic signed [DATA_W-1:0] push_value;
  } deq_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    deq_status_e              status;
  } deq_out_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic load_out;
  } deq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } deq_sts_t;

  // Advance a ring index by one slot
  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
    return (idx == IDX_LAST) ? '0 : idx + 1'b1;
  endfunction

  // Step a ring index back by one slot
  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] idx);
    return (idx == '0) ? IDX_LAST : idx - 1'b1;
  endfunction

endpackage

// ===== design/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Sequences each item through capture, execute and result load.
// ----------------------------------------------------------------------------
module deq_ctrl
  import deq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  deq_sts_t sts_i,
  output deq_cmd_t cmd_o
);

  deq_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Commands and input handshake
  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o.load_item = 1'b0;
    cmd_o.exec      = 1'b0;
    cmd_o.load_out  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      ST_DONE: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/deq_dp.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Entry memory, head and tail indices, element count, and the result register.
// ----------------------------------------------------------------------------
`include "double_ended_queue_top_macros.svh"

module deq_dp
  import deq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  deq_in_t  in_data_i,
  input  deq_cmd_t cmd_i,
  output deq_sts_t sts_o,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  output deq_out_t out_data_o
);

  // Captured item
  deq_op_e           op_q;
  logic [DATA_W-1:0] val_q;

  // Ring state
  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Entry memory
  logic [DATA_W-1:0] entry_store_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;
  logic              mem_we;
  logic              mem_re;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  rd_addr;

  // Pending result parts
  deq_status_e       res_status_q, res_status_d;
  logic              use_rd_q, use_rd_d;
  logic [DATA_W-1:0] imm_q, imm_d;

  // Result register
  logic     out_valid_q;
  deq_out_t out_q;

  logic empty;
  logic full;

  assign empty = (cnt_q == '0);
  assign full  = (cnt_q == CNT_FULL);

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q  <= in_data_i.opcode;
      val_q <= in_data_i.push_value;
    end
  end

  // Execute the captured opcode
  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    cnt_d        = cnt_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    wr_addr      = tail_q;
    rd_addr      = head_q;
    res_status_d = STAT_OK;
    use_rd_d     = 1'b0;
    imm_d        = '0;
    if (cmd_i.exec) begin
      unique case (op_q) inside
        OP_PUSH_FRONT: begin
          if (full) begin
            res_status_d = STAT_FULL;
          end else begin
            head_d  = wrap_dec(head_q);
            wr_addr = wrap_dec(head_q);
            mem_we  = 1'b1;
            cnt_d   = cnt_q + CNT_W'(1);
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            res_status_d = STAT_FULL;
          end else begin
            wr_addr = tail_q;
            tail_d  = wrap_inc(tail_q);
            mem_we  = 1'b1;
            cnt_d   = cnt_q + CNT_W'(1);
          end
        end
        OP_POP_FRONT, OP_PEEK_FRONT: begin
          if (empty) begin
            res_status_d = STAT_EMPTY;
          end else begin
            rd_addr  = head_q;
            mem_re   = 1'b1;
            use_rd_d = 1'b1;
            if (op_q == OP_POP_FRONT) begin
              head_d = wrap_inc(head_q);
              cnt_d  = cnt_q - CNT_W'(1);
            end
          end
        end
        OP_POP_BACK, OP_PEEK_BACK: begin
          if (empty) begin
            res_status_d = STAT_EMPTY;
          end else begin
            rd_addr  = wrap_dec(tail_q);
            mem_re   = 1'b1;
            use_rd_d = 1'b1;
            if (op_q == OP_POP_BACK) begin
              tail_d = wrap_dec(tail_q);
              cnt_d  = cnt_q - CNT_W'(1);
            end
          end
        end
        OP_COUNT: begin
          imm_d = DATA_W'(cnt_q);
        end
        OP_CLEAR: begin
          head_d = '0;
          tail_d = '0;
          cnt_d  = '0;
        end
        default: begin
          res_status_d = STAT_OK;
        end
      endcase
    end
  end

  // Ring indices and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // Write and read the entry memory
  always_ff @(posedge clk_i) begin
    if (mem_we) entry_store_q[wr_addr] <= val_q;
    if (mem_re) rd_data_q <= entry_store_q[rd_addr];
  end

  // Hold the result parts until the read data lands
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_status_q <= res_status_d;
      use_rd_q     <= use_rd_d;
      imm_q        <= imm_d;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.data_out <= use_rd_q ? rd_data_q : imm_q;
      out_q.status   <= res_status_q;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

  // Checks on the ring bookkeeping
  `DEQ_ASSERT(a_cnt_bound, cnt_q <= CNT_FULL, "element count above depth")
  `DEQ_ASSERT_IMPL(a_empty_idx, empty, head_q == tail_q, "empty ring with split indices")
  `DEQ_ASSERT_IMPL(a_full_idx, full, head_q == tail_q, "full ring with split indices")
  `DEQ_ASSERT_NEXT(a_full_drop, cmd_i.exec && full && (op_q == OP_PUSH_FRONT ||
    op_q == OP_PUSH_BACK), $stable(cnt_q) && $stable(head_q) && $stable(tail_q),
    "push into full ring changed state")
  `DEQ_ASSERT_NEXT(a_load_valid, cmd_i.load_out, out_valid_q, "loaded result not shown")

endmodule

// ===== design/double_ended_queue_top.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue top level
// Ring-buffer deque of signed 32-bit values with one result per item.
//
//   channel   signals                          struct
//   input     in_valid_i / in_ready_o          in_data_i  (opcode, push_value)
//   output    out_valid_o / out_ready_i        out_data_o (data_out, status)
//
// Each item goes through capture, execute (index update and one memory
// access), and result load; the registered memory read sets the middle step.
// Reset clears the indices, the count and the result flag; memory is not
// cleared and needs no sweep. A stalled output holds the result register and
// the next item waits in the controller; a new item is taken while a result
// is still waiting.
// ----------------------------------------------------------------------------
module double_ended_queue_top
  import deq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  deq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output deq_out_t out_data_o
);

  deq_cmd_t cmd;
  deq_sts_t sts;

  // Sequence items
  deq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Store entries and form results
  deq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/tb_double_ended_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives opcode items into the deque through a valid/ready driver and checks
// every result against a behavioral ring model that is updated on each
// accepted item. Covers empty-queue errors, wrap of both indices, clear,
// and a long random mix with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_top;
  import deq_pkg::*;

  localparam int RUN_LIMIT    = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 627;

  logic     clk_i;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  deq_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  deq_out_t out_data;

  // Items waiting to be driven and results waiting to come back
  deq_in_t  op_backlog[$];
  deq_out_t deque_results[$];

  // Ring model state
  logic signed [DATA_W-1:0] ring_mem [DEPTH];
  logic [IDX_W-1:0]         ring_head = '0;
  logic [IDX_W-1:0]         ring_tail = '0;
  logic [CNT_W-1:0]         ring_cnt  = '0;
  logic [CNT_W-1:0]         peak_cnt  = '0;

  int cycle_cnt    = 0;
  int fail_cnt     = 0;
  int checked_cnt  = 0;
  int empty_errs   = 0;
  int full_drops   = 0;

  double_ended_queue_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Apply one item to the ring model and return the result it must produce
  function automatic deq_out_t apply_deque_op(deq_in_t item);
    deq_out_t         res;
    logic [IDX_W-1:0] last;
    res.data_out = '0;
    res.status   = STAT_OK;
    case (item.opcode)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (ring_cnt == CNT_FULL) begin
          res.status = STAT_FULL;
        end else if (item.opcode == OP_PUSH_FRONT) begin
          ring_head = (ring_head == '0) ? IDX_LAST : ring_head - 1'b1;
          ring_mem[ring_head] = item.push_value;
          ring_cnt = ring_cnt + 1'b1;
        end else begin
          ring_mem[ring_tail] = item.push_value;
          ring_tail = (ring_tail == IDX_LAST) ? '0 : ring_tail + 1'b1;
          ring_cnt = ring_cnt + 1'b1;
        end
      end
      OP_POP_FRONT, OP_PEEK_FRONT: begin
        if (ring_cnt == '0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.data_out = ring_mem[ring_head];
          if (item.opcode == OP_POP_FRONT) begin
            ring_head = (ring_head == IDX_LAST) ? '0 : ring_head + 1'b1;
            ring_cnt = ring_cnt - 1'b1;
          end
        end
      end
      OP_POP_BACK, OP_PEEK_BACK: begin
        if (ring_cnt == '0) begin
          res.status = STAT_EMPTY;
        end else begin
          last = (ring_tail == '0) ? IDX_LAST : ring_tail - 1'b1;
          res.data_out = ring_mem[last];
          if (item.opcode == OP_POP_BACK) begin
            ring_tail = last;
            ring_cnt = ring_cnt - 1'b1;
          end
        end
      end
      OP_COUNT: begin
        res.data_out = DATA_W'(ring_cnt);
      end
      default: begin
        ring_head = '0;
        ring_tail = '0;
        ring_cnt  = '0;
      end
    endcase
    if (ring_cnt > peak_cnt) peak_cnt = ring_cnt;
    if (res.status == STAT_EMPTY) empty_errs++;
    if (res.status == STAT_FULL) full_drops++;
    return res;
  endfunction

  // Hold off with probability 28/100, except inside one steady window
  function automatic bit hold_off();
    if (cycle_cnt >= 600 && cycle_cnt < 1400) return 1'b0;
    return $urandom_range(0, 99) < 28;
  endfunction

  function automatic deq_op_e random_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 19) return OP_PUSH_FRONT;
    if (r < 38) return OP_PUSH_BACK;
    if (r < 54) return OP_POP_FRONT;
    if (r < 70) return OP_POP_BACK;
    if (r < 78) return OP_PEEK_FRONT;
    if (r < 86) return OP_PEEK_BACK;
    if (r < 98) return OP_COUNT;
    return OP_CLEAR;
  endfunction

  task automatic queue_op(deq_op_e op, logic signed [DATA_W-1:0] value);
    deq_in_t it;
    it.opcode     = op;
    it.push_value = value;
    op_backlog.push_back(it);
  endtask

  // Driver: record accepted items, then present the next one or idle
  always @(posedge clk_i) begin
    logic    nxt_valid;
    deq_in_t nxt_data;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_data  = in_data;
      if (in_valid && in_ready) begin
        deque_results.push_back(apply_deque_op(in_data));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && op_backlog.size() > 0 && !hold_off()) begin
        nxt_valid = 1'b1;
        nxt_data  = op_backlog.pop_front();
      end
      in_valid <= nxt_valid;
      in_data  <= nxt_data;
    end
  end

  // Monitor: compare each result with the oldest expectation, stall at random
  always @(posedge clk_i) begin
    deq_out_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (deque_results.size() == 0) begin
          $error("result with nothing expected: data_out %0d status %0d",
                 out_data.data_out, out_data.status);
          fail_cnt++;
        end else begin
          want = deque_results.pop_front();
          checked_cnt++;
          if (out_data.data_out !== want.data_out) begin
            $error("data_out mismatch: expected %0d, actual %0d",
                   want.data_out, out_data.data_out);
            fail_cnt++;
          end
          if (out_data.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   want.status, out_data.status);
            fail_cnt++;
          end
        end
      end
      out_ready <= !hold_off();
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= RUN_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int i;

    // Empty corners, extremes at both ends, pops and peeks from each side
    queue_op(OP_POP_FRONT, 32'sd5);
    queue_op(OP_POP_BACK, -32'sd5);
    queue_op(OP_PEEK_FRONT, 32'h7FFF_FFFF);
    queue_op(OP_PEEK_BACK, 32'h8000_0000);
    queue_op(OP_COUNT, '1);
    queue_op(OP_PUSH_FRONT, 32'h8000_0000);
    queue_op(OP_PUSH_BACK, 32'h7FFF_FFFF);
    queue_op(OP_PUSH_FRONT, -32'sd1);
    queue_op(OP_PUSH_BACK, 32'sd0);
    queue_op(OP_PEEK_FRONT, '0);
    queue_op(OP_PEEK_BACK, '0);
    queue_op(OP_COUNT, '0);
    queue_op(OP_POP_BACK, '0);
    queue_op(OP_POP_FRONT, '0);
    queue_op(OP_POP_FRONT, '0);
    queue_op(OP_POP_BACK, '0);
    queue_op(OP_POP_FRONT, '0);
    queue_op(OP_PUSH_BACK, 32'sd123);
    queue_op(OP_PUSH_FRONT, -32'sd456);
    queue_op(OP_CLEAR, 32'h5A5A_A5A5);
    queue_op(OP_COUNT, '0);
    queue_op(OP_PEEK_BACK, '0);
    queue_op(OP_CLEAR, '0);

    // Random mix; pushes slightly outweigh pops, rare clears restart from empty
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      queue_op(random_op(), $urandom());
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sample the bookkeeping away from the driving edge
    while (op_backlog.size() != 0 || in_valid || deque_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d results: %0d empty-queue errors, %0d full-queue drops,",
             checked_cnt, empty_errs, full_drops);
    $display("peak occupancy %0d of %0d entries.", peak_cnt, DEPTH);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
